### src/bfe_pkg.sv
package bfe_pkg;

   localparam int DEF_MAX_BITS   = 65536;
   localparam int DEF_MAX_HASHES = 16;

   localparam int BITS_RESET   = 65536;
   localparam int HASHES_RESET = 7;
   localparam int BITS_FIELD_W = 17;
   localparam int HASH_FIELD_W = 5;

   localparam logic [63:0] OFFSET_BASIS = 64'hcbf29ce484222325;
   localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
   localparam int          FNV_SHIFT    = 40;
   localparam logic [63:0] MIX_K1       = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_K2       = 64'hc4ceb9fe1a85ec53;
   localparam int          MIX_SHIFT    = 33;

   localparam int ROW_W     = 64;
   localparam int ROW_SHIFT = 6;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_TEST  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic REG_BIT_COUNT  = 1'b0;
   localparam logic REG_HASH_COUNT = 1'b1;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] key_byte;
      logic       has_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  done_cmd;
      logic        maybe_present;
      logic [31:0] items_added;
   } rsp_type;

   function automatic logic [63:0] xor_shift(input logic [63:0] v);
      return v ^ (v >> MIX_SHIFT);
   endfunction

endpackage

### src/bfe_mix.sv
module bfe_mix (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] din,
   output logic        done,
   output logic [63:0] dout
);
   import bfe_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        pass_ff, pass_in;
   logic [2:0]  step_ff, step_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;

   logic [63:0] kc;
   logic [1:0]  part;
   logic [31:0] op_a, op_b;
   logic [63:0] sum;

   // 64x64 mod 2^64 product from three 32x32 partial products
   always_comb begin
      kc   = pass_ff ? MIX_K2 : MIX_K1;
      part = step_ff[2:1];
      op_a = (part == 2'd2) ? x_ff[63:32] : x_ff[31:0];
      op_b = (part == 2'd1) ? kc[63:32] : kc[31:0];
      sum  = (part == 2'd0) ? acc_ff + prod_ff : acc_ff + {prod_ff[31:0], 32'd0};

      busy_in = busy_ff;
      done_in = 1'b0;
      pass_in = pass_ff;
      step_in = step_ff;
      x_in    = x_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;

      if (start) begin
         busy_in = 1'b1;
         pass_in = 1'b0;
         step_in = 3'd0;
         x_in    = xor_shift(din);
         acc_in  = 64'd0;
      end else if (busy_ff) begin
         if (!step_ff[0]) begin
            prod_in = op_a * op_b;
            step_in = step_ff + 3'd1;
         end else if (step_ff == 3'd5) begin
            x_in    = xor_shift(sum);
            acc_in  = 64'd0;
            step_in = 3'd0;
            if (pass_ff) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               pass_in = 1'b1;
            end
         end else begin
            acc_in  = sum;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pass_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         pass_ff <= pass_in;
         step_ff <= step_in;
      end
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign dout = x_ff;

endmodule

### src/bfe_rem.sv
module bfe_rem #(
   parameter int NW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   dividend,
   input  logic [NW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] rem
);
   import bfe_pkg::*;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [63:0]   dvd_ff, dvd_in;
   logic [NW-1:0] rem_ff, rem_in;

   logic [NW:0]   trial;
   logic [NW-1:0] r;

   // restoring remainder, four dividend bits per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      r       = rem_ff;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int k = 0; k < 4; k++) begin
            trial = {r, dvd_ff[63-k]};
            if (trial >= {1'b0, divisor}) trial = trial - {1'b0, divisor};
            r = trial[NW-1:0];
         end
         rem_in = r;
         dvd_in = dvd_ff << 4;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

### src/bfe_store.sv
module bfe_store #(
   parameter int MAX_BITS = bfe_pkg::DEF_MAX_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear_start,
   output logic                  busy,
   input  logic                  rd_en,
   input  logic                  wr_en,
   input  logic [(((MAX_BITS + bfe_pkg::ROW_W - 1) / bfe_pkg::ROW_W) > 1 ?
                 $clog2((MAX_BITS + bfe_pkg::ROW_W - 1) / bfe_pkg::ROW_W) : 1) - 1:0] row,
   input  logic [bfe_pkg::ROW_W-1:0] wr_data,
   output logic [bfe_pkg::ROW_W-1:0] rd_data
);
   import bfe_pkg::*;

   localparam int ROWS = (MAX_BITS + ROW_W - 1) / ROW_W;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [ROW_W-1:0] store_mem [ROWS];
   logic [ROW_W-1:0] rd_data_ff;
   logic             sweep_ff, sweep_in;
   logic [RW-1:0]    sweep_row_ff, sweep_row_in;

   logic             we;
   logic [RW-1:0]    waddr;
   logic [ROW_W-1:0] wdata;

   always_comb begin
      sweep_in     = sweep_ff;
      sweep_row_in = sweep_row_ff;
      if (clear_start) begin
         sweep_in     = 1'b1;
         sweep_row_in = '0;
      end else if (sweep_ff) begin
         sweep_row_in = sweep_row_ff + RW'(1);
         if (sweep_row_ff == RW'(ROWS - 1)) sweep_in = 1'b0;
      end
      we    = sweep_ff | wr_en;
      waddr = sweep_ff ? sweep_row_ff : row;
      wdata = sweep_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= 1'b1;
         sweep_row_ff <= '0;
      end else begin
         sweep_ff     <= sweep_in;
         sweep_row_ff <= sweep_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) store_mem[waddr] <= wdata;
      if (rd_en) rd_data_ff <= store_mem[row];
   end

   assign busy    = sweep_ff;
   assign rd_data = rd_data_ff;

endmodule

### src/bloom_filter_engine.sv
// bloom filter engine: keys stream in one byte per beat on the req channel
// (cmd add or test, key_byte, has_byte, last_byte); a beat with last_byte
// ends the key and yields one rsp beat (done_cmd, maybe_present, items_added)
// a clear beat empties the filter and also yields one rsp beat
// csr port: bit_count at 0x0, hash_count at 0x4, clamped on write
// a byte beat that does not end a key only folds into the running hash in idle
// a key end runs the murmur-style mixer (one shared 32x32 multiplier),
// three remainder passes (h1, h2 and 2^64 mod bit_count) and, per probe,
// a read of a 64-bit row of the bit memory and, for an add only, the
// write-back of that row with the probe bit set
// a clear is one sweep of the memory over its MAX_BITS/64 rows (1024 by default)
// reset starts the same sweep; req_stall stays high until it is over
// while rsp_stall is high a finished beat waits in the output register and
// the next byte beats are still taken; a second result waits until it drains
// no commands are taken while a key end or clear is being worked
module bloom_filter_engine #(
   parameter int MAX_BITS   = bfe_pkg::DEF_MAX_BITS,
   parameter int MAX_HASHES = bfe_pkg::DEF_MAX_HASHES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bfe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bfe_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import bfe_pkg::*;

   localparam int NW   = $clog2(MAX_BITS + 1);
   localparam int HW   = $clog2(MAX_HASHES + 1);
   localparam int ROWS = (MAX_BITS + ROW_W - 1) / ROW_W;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_MIX   = 4'd2;
   localparam logic [3:0] S_MOD1  = 4'd3;
   localparam logic [3:0] S_MOD2  = 4'd4;
   localparam logic [3:0] S_MOD3  = 4'd5;
   localparam logic [3:0] S_RD    = 4'd6;
   localparam logic [3:0] S_WR    = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   function automatic logic [31:0] clamp_bits(input logic [31:0] v);
      logic [31:0] c;
      c = v;
      if (c < 32'd64) c = 32'd64;
      if (c > 32'(MAX_BITS)) c = 32'(MAX_BITS);
      c = c & ~32'd7;
      if (c < 32'd64) c = 32'd64;
      return c;
   endfunction

   function automatic logic [31:0] clamp_hashes(input logic [31:0] v);
      logic [31:0] c;
      c = v;
      if (c < 32'd1) c = 32'd1;
      if (c > 32'(MAX_HASHES)) c = 32'(MAX_HASHES);
      return c;
   endfunction

   localparam logic [NW-1:0] BITS_RST = NW'(clamp_bits(32'(BITS_RESET)));
   localparam logic [HW-1:0] HASH_RST = HW'(clamp_hashes(32'(HASHES_RESET)));

   // config registers
   logic [NW-1:0] bit_count_ff, bit_count_in;
   logic [HW-1:0] hash_count_ff, hash_count_in;
   logic          csr_wr;

   // sequencer and key state
   logic [3:0]    state_ff, state_in;
   logic [63:0]   hash_ff, hash_in;
   logic [63:0]   h1_ff, h1_in;
   logic [63:0]   h2_ff, h2_in;
   logic [63:0]   s_ff, s_in;
   logic [NW-1:0] r_ff, r_in;
   logic [NW-1:0] h2m_ff, h2m_in;
   logic [NW-1:0] cm_ff, cm_in;
   logic [HW-1:0] i_ff, i_in;
   logic          present_ff, present_in;
   logic [1:0]    op_ff, op_in;
   logic          clr_out_ff, clr_out_in;
   logic [31:0]   count_ff, count_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // unit hookups
   logic          accept;
   logic [63:0]   fold, fold_t;
   logic          mix_start, mix_done;
   logic [63:0]   mix_out;
   logic          rem_start, rem_done;
   logic [63:0]   rem_dvd;
   logic [NW-1:0] rem_out;
   logic          clear_start, store_busy;
   logic          mem_rd, mem_wr;
   logic [RW-1:0] mem_row;
   logic [ROW_W-1:0] mem_wdata, mem_rdata;
   logic          probe_bit;
   logic [64:0]   s_next;
   logic [NW:0]   t_step, cm_tmp;
   logic [31:0]   count_inc;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_HASH_COUNT) ? 32'(hash_count_ff)
                                                        : 32'(bit_count_ff);

   always_comb begin
      bit_count_in  = bit_count_ff;
      hash_count_in = hash_count_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_BIT_COUNT)
            bit_count_in = NW'(clamp_bits(32'(csr_pwdata[BITS_FIELD_W-1:0])));
         else
            hash_count_in = HW'(clamp_hashes(32'(csr_pwdata[HASH_FIELD_W-1:0])));
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // fnv-1a fold: prime is 2^40 + 0x1b3
   assign fold_t = hash_ff ^ {56'd0, req_data.key_byte};
   assign fold   = req_data.has_byte ? (fold_t << FNV_SHIFT) + fold_t * FNV_PRIME_LO
                                     : hash_ff;

   assign clear_start = accept && (req_data.cmd == CMD_CLEAR);
   assign mix_start   = accept && (req_data.cmd == CMD_ADD || req_data.cmd == CMD_TEST)
                        && req_data.last_byte;

   assign rem_start = ((state_ff == S_MIX) && mix_done) ||
                      ((state_ff == S_MOD1) && rem_done) ||
                      ((state_ff == S_MOD2) && rem_done);
   assign rem_dvd   = (state_ff == S_MIX)  ? h1_ff :
                      (state_ff == S_MOD1) ? h2_ff : {64{1'b1}};

   // probe memory access: read in S_RD, update or check in S_WR
   assign mem_row   = RW'(r_ff >> ROW_SHIFT);
   assign mem_rd    = (state_ff == S_RD);
   assign probe_bit = mem_rdata[r_ff[ROW_SHIFT-1:0]];
   assign mem_wr    = (state_ff == S_WR) && (op_ff == CMD_ADD);
   assign mem_wdata = mem_rdata | (ROW_W'(1) << r_ff[ROW_SHIFT-1:0]);

   assign count_inc = (count_ff == 32'hFFFF_FFFF) ? count_ff : count_ff + 32'd1;

   // next probe: track the 64-bit sum for its wrap, fold 2^64 mod n back in
   always_comb begin
      s_next = {1'b0, s_ff} + {1'b0, h2_ff};
      t_step = {1'b0, r_ff} + {1'b0, h2m_ff};
      if (t_step >= {1'b0, bit_count_ff}) t_step = t_step - {1'b0, bit_count_ff};
      if (s_next[64]) begin
         if (t_step >= {1'b0, cm_ff}) t_step = t_step - {1'b0, cm_ff};
         else t_step = t_step + {1'b0, bit_count_ff} - {1'b0, cm_ff};
      end
      cm_tmp = {1'b0, rem_out} + (NW+1)'(1);
      if (cm_tmp == {1'b0, bit_count_ff}) cm_tmp = '0;
   end

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      h2m_in       = h2m_ff;
      cm_in        = cm_ff;
      i_in         = i_ff;
      present_in   = present_ff;
      op_in        = op_ff;
      clr_out_in   = clr_out_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.cmd)
                  CMD_CLEAR: begin
                     hash_in    = OFFSET_BASIS;
                     count_in   = 32'd0;
                     res_in     = '{done_cmd: CMD_CLEAR, maybe_present: 1'b0,
                                    items_added: 32'd0};
                     clr_out_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  CMD_ADD, CMD_TEST: begin
                     if (req_data.last_byte) begin
                        h1_in    = fold;
                        hash_in  = OFFSET_BASIS;
                        op_in    = req_data.cmd;
                        state_in = S_MIX;
                     end else begin
                        hash_in = fold;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CLEAR: begin
            if (!store_busy) begin
               state_in   = clr_out_ff ? S_DONE : S_IDLE;
               clr_out_in = 1'b0;
            end
         end
         S_MIX: begin
            if (mix_done) begin
               h2_in    = mix_out;
               state_in = S_MOD1;
            end
         end
         S_MOD1: begin
            if (rem_done) begin
               r_in     = rem_out;
               s_in     = h1_ff;
               state_in = S_MOD2;
            end
         end
         S_MOD2: begin
            if (rem_done) begin
               h2m_in   = rem_out;
               state_in = S_MOD3;
            end
         end
         S_MOD3: begin
            if (rem_done) begin
               cm_in      = cm_tmp[NW-1:0];
               i_in       = '0;
               present_in = 1'b1;
               state_in   = S_RD;
            end
         end
         S_RD: state_in = S_WR;
         S_WR: begin
            r_in = t_step[NW-1:0];
            s_in = s_next[63:0];
            i_in = i_ff + HW'(1);
            if (!probe_bit) present_in = 1'b0;
            if (i_ff == hash_count_ff - HW'(1)) begin
               state_in = S_DONE;
               if (op_ff == CMD_ADD) begin
                  count_in = count_inc;
                  res_in   = '{done_cmd: CMD_ADD, maybe_present: 1'b0,
                              items_added: count_inc};
               end else begin
                  res_in   = '{done_cmd: CMD_TEST,
                              maybe_present: present_ff && probe_bit,
                              items_added: count_ff};
               end
            end else begin
               state_in = S_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff  <= BITS_RST;
         hash_count_ff <= HASH_RST;
         state_ff      <= S_CLEAR;
         hash_ff       <= OFFSET_BASIS;
         count_ff      <= 32'd0;
         clr_out_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bit_count_ff  <= bit_count_in;
         hash_count_ff <= hash_count_in;
         state_ff      <= state_in;
         hash_ff       <= hash_in;
         count_ff      <= count_in;
         clr_out_ff    <= clr_out_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      h1_ff       <= h1_in;
      h2_ff       <= h2_in;
      s_ff        <= s_in;
      r_ff        <= r_in;
      h2m_ff      <= h2m_in;
      cm_ff       <= cm_in;
      i_ff        <= i_in;
      present_ff  <= present_in;
      op_ff       <= op_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bfe_mix u_mix (
      .clock (clock),
      .reset (reset),
      .start (mix_start),
      .din   (fold),
      .done  (mix_done),
      .dout  (mix_out)
   );

   bfe_rem #(.NW(NW)) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_dvd),
      .divisor  (bit_count_ff),
      .done     (rem_done),
      .rem      (rem_out)
   );

   bfe_store #(.MAX_BITS(MAX_BITS)) u_store (
      .clock       (clock),
      .reset       (reset),
      .clear_start (clear_start),
      .busy        (store_busy),
      .rd_en       (mem_rd),
      .wr_en       (mem_wr),
      .row         (mem_row),
      .wr_data     (mem_wdata),
      .rd_data     (mem_rdata)
   );

endmodule

### tb/sv/bloom_filter_engine_checker.sv
`timescale 1ns / 100ps

module bloom_filter_engine_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  bfe_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  bfe_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_seen
);
   import bfe_pkg::*;

   localparam int NBITS = DEF_MAX_BITS;

   logic [NBITS-1:0] filter_mem;
   logic [63:0]      key_hash;
   logic [31:0]      added_count;
   logic [16:0]      filter_size;
   logic [4:0]       probe_count;
   rsp_type          rsp_queue[$];

   function automatic logic [16:0] clamp_size(input logic [31:0] v);
      logic [31:0] c;
      c = v & 32'h1ffff;
      if (c < 64) c = 64;
      if (c > NBITS) c = NBITS;
      c = c & ~32'd7;
      return c[16:0];
   endfunction

   function automatic logic [4:0] clamp_probes(input logic [31:0] v);
      logic [31:0] c;
      c = v & 32'h1f;
      if (c < 1) c = 1;
      if (c > DEF_MAX_HASHES) c = DEF_MAX_HASHES;
      return c[4:0];
   endfunction

   function automatic logic [63:0] mix_hash(input logic [63:0] x);
      x = x ^ (x >> 33);
      x = x * 64'hff51afd7ed558ccd;
      x = x ^ (x >> 33);
      x = x * 64'hc4ceb9fe1a85ec53;
      x = x ^ (x >> 33);
      return x;
   endfunction

   task automatic predict_beat(input req_type b);
      logic [63:0] h1, h2, idx;
      logic        hit;
      rsp_type     r;
      if (b.cmd == 2'd3) return;
      if (b.cmd == CMD_CLEAR) begin
         filter_mem  = '0;
         added_count = 0;
         key_hash    = OFFSET_BASIS;
         r = '{done_cmd: CMD_CLEAR, maybe_present: 1'b0, items_added: 32'd0};
         rsp_queue.push_back(r);
         return;
      end
      if (b.has_byte) key_hash = (key_hash ^ {56'd0, b.key_byte}) * 64'h100000001b3;
      if (!b.last_byte) return;
      h1 = key_hash;
      h2 = mix_hash(h1);
      key_hash = OFFSET_BASIS;
      hit = 1'b1;
      for (int i = 0; i < probe_count; i++) begin
         idx = (h1 + 64'(i) * h2) % {47'd0, filter_size};
         if (b.cmd == CMD_ADD) filter_mem[idx] = 1'b1;
         else if (!filter_mem[idx]) hit = 1'b0;
      end
      if (b.cmd == CMD_ADD) begin
         hit = 1'b0;
         if (added_count != 32'hffffffff) added_count++;
      end
      r = '{done_cmd: b.cmd, maybe_present: hit, items_added: added_count};
      rsp_queue.push_back(r);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         filter_mem  = '0;
         key_hash    = OFFSET_BASIS;
         added_count = 0;
         filter_size = 17'(BITS_RESET);
         probe_count = 5'(HASHES_RESET);
         rsp_queue.delete();
         fail_count    = 0;
         pending_count <= 0;
         rsp_seen      <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == REG_BIT_COUNT) filter_size = clamp_size(csr_pwdata);
            else probe_count = clamp_probes(csr_pwdata);
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_seen <= rsp_seen + 1;
            if (rsp_queue.size() == 0) begin
               $error("unexpected beat: %p", rsp_data);
               fail_count = fail_count + 1;
            end else begin
               e = rsp_queue.pop_front();
               if (rsp_data.done_cmd !== e.done_cmd) begin
                  $error("done_cmd exp %0d got %0d", e.done_cmd, rsp_data.done_cmd);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.maybe_present !== e.maybe_present) begin
                  $error("maybe_present exp %0d got %0d", e.maybe_present,
                         rsp_data.maybe_present);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.items_added !== e.items_added) begin
                  $error("items_added exp %0d got %0d", e.items_added,
                         rsp_data.items_added);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) predict_beat(req_data);
         pending_count <= rsp_queue.size();
      end
   end

endmodule

### tb/sv/bloom_filter_engine_tb.sv
`timescale 1ns / 100ps

module bloom_filter_engine_tb;
   import bfe_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, pending_count, rsp_seen;

   // idle and stall odds in percent, hold-off length for the stall burst
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_len = 0;
   int  hold_count = 0;
   longint cycle_count = 0;
   int  beats_sent = 0;

   // 6 ns high, 6 ns low
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   bloom_filter_engine u_top (.*);

   bloom_filter_engine_checker u_check (.*);

   // receiver stall: random, or a long hold-off counted here
   always @(posedge clock) begin
      if (hold_count < hold_len) begin
         hold_count <= hold_count + 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog: fails the run when cycle_count passes its limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 8000000) begin
         $display("** bloom_filter_engine: FAILED **");
         $finish;
      end
   end

   // one beat; valid stays up across back-to-back beats
   task automatic send_beat(input logic [1:0] c, input logic [7:0] b,
                            input logic h, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{cmd: c, key_byte: b, has_byte: h, last_byte: l};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // let any unfinished key-end work drain
      repeat (2000) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // a key picked at random from a small pool so tests hit earlier adds
   task automatic send_key(input logic [1:0] c, input int len, input int pool);
      int s;
      s = $urandom_range(pool);
      for (int i = 0; i < len; i++)
         send_beat((i == len - 1) ? c : 2'($urandom_range(1)),
                   8'(s * 37 + i * 11), 1'b1, i == len - 1);
      if (len == 0) send_beat(c, 8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic random_phase(input int n_beats, input int pool);
      int r, stop;
      stop = beats_sent + n_beats;
      while (beats_sent < stop) begin
         r = $urandom_range(99);
         if (r < 45) send_key(CMD_ADD, $urandom_range(6), pool);
         else if (r < 90) send_key(CMD_TEST, $urandom_range(6), pool);
         else if (r < 92) send_beat(CMD_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
         else if (r < 95) send_beat(2'd3, 8'($urandom), 1'($urandom), 1'($urandom));
         else send_beat(2'($urandom_range(1)), 8'($urandom), 1'($urandom),
                        1'($urandom));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes, empty key, mixed commands, unused cmd, clear
      send_beat(CMD_ADD, 8'h00, 1'b1, 1'b0);
      send_beat(CMD_ADD, 8'hff, 1'b1, 1'b1);
      send_beat(CMD_TEST, 8'h00, 1'b1, 1'b0);
      send_beat(CMD_TEST, 8'hff, 1'b1, 1'b1);
      send_beat(CMD_TEST, 8'h55, 1'b0, 1'b1);
      send_beat(CMD_ADD, 8'haa, 1'b0, 1'b1);
      send_beat(CMD_TEST, 8'h12, 1'b0, 1'b1);
      send_beat(CMD_TEST, 8'h34, 1'b1, 1'b0);
      send_beat(CMD_ADD, 8'h56, 1'b1, 1'b1);
      send_beat(CMD_TEST, 8'h34, 1'b1, 1'b0);
      send_beat(CMD_TEST, 8'h56, 1'b1, 1'b1);
      send_beat(2'd3, 8'hff, 1'b1, 1'b1);
      send_beat(CMD_TEST, 8'h01, 1'b1, 1'b1);
      send_beat(CMD_CLEAR, 8'hff, 1'b1, 1'b1);
      send_beat(CMD_TEST, 8'hff, 1'b1, 1'b1);
      send_beat(CMD_ADD, 8'h77, 1'b1, 1'b0);
      send_beat(CMD_CLEAR, 8'h00, 1'b0, 1'b0);
      send_beat(CMD_TEST, 8'h77, 1'b1, 1'b1);
      go_idle();

      // size extremes, below- and above-range values clamp, bits beyond the field are dropped
      write_reg(REG_BIT_COUNT, 32'd0);
      write_reg(REG_HASH_COUNT, 32'd0);
      random_phase(150, 40);
      go_idle();
      write_reg(REG_BIT_COUNT, 32'hffffffff);
      write_reg(REG_HASH_COUNT, 32'd31);
      random_phase(150, 20);
      go_idle();

      // small filter, full probes: fills up so tests often hit
      write_reg(REG_BIT_COUNT, 32'd133);
      write_reg(REG_HASH_COUNT, 32'd16);
      send_idle_pct = 81;
      random_phase(200, 60);
      go_idle();

      write_reg(REG_BIT_COUNT, 32'd1000);
      write_reg(REG_HASH_COUNT, 32'd3);
      send_idle_pct = 0;
      recv_stall_pct = 81;
      random_phase(200, 30);
      // long hold-off while keys keep coming
      hold_len = 3000;
      random_phase(60, 30);
      go_idle();

      write_reg(REG_BIT_COUNT, 32'd65536);
      write_reg(REG_HASH_COUNT, 32'd1);
      send_idle_pct = 37;
      recv_stall_pct = 37;
      random_phase(200, 50);
      go_idle();

      write_reg(REG_BIT_COUNT, 32'd64);
      write_reg(REG_HASH_COUNT, 32'd8);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_phase(200, 80);
      go_idle();

      $display("run covered %0d request beats and %0d result beats", beats_sent, rsp_seen);
      $display("across six size and probe settings with idle and stall mixes");
      if (fail_count == 0) begin
         $display("** bloom_filter_engine: PASSED **");
      end else begin
         $display("** bloom_filter_engine: FAILED **");
      end
      $finish;
   end

endmodule
